@@ design/abse_pkg.sv @@
// Package for the aligned byte stack engine.
// Holds the request and response payload types, fault codes, controller states
// and the command and status structs shared by the controller and the datapath.
package abse_pkg;

    localparam int LEVEL_W = 13;
    localparam int WORDS_W = 4;   // rounded size in 32-bit words, 0 to 8
    localparam int CNT_W   = 3;   // word index within one push, 0 to 7

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OVER  = 2'd1;
    localparam logic [1:0] FAULT_UNDER = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] value;
        logic [4:0]  size_bytes;
    } req_t;

    typedef struct packed {
        logic [31:0]        pop_value;
        logic [1:0]         fault;
        logic [LEVEL_W-1:0] stack_level;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE,
        ST_READ,
        ST_RWAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;     // latch the incoming request
        logic check;        // evaluate the request, set fault, pop moves pointer
        logic write_word;   // write one word of a push
        logic read_word;    // issue the read of the popped word
        logic capture;      // take the read data
        logic load_result;  // move the result into the response register
    } cmd_t;

    typedef struct packed {
        logic zero_size;
        logic fault_any;
        logic is_pop;
        logic last_word;
        logic out_free;
    } status_t;

endpackage

@@ design/abse_ram.sv @@
// Generic single-port RAM with a registered read.
// Standalone; used by the datapath for the word-wide stack store.
module abse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/abse_ctrl.sv @@
// Controller state machine for the aligned byte stack engine.
// Depends on abse_pkg; drives the datapath through cmd_t and reads status_t.
module abse_ctrl
    import abse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.zero_size || status.fault_any)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.is_pop)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.last_word)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.write_word = 1'b1;
            end
            ST_READ:
            begin
                cmd.read_word = 1'b1;
            end
            ST_RWAIT:
            begin
                cmd.capture = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_result = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/abse_dp.sv @@
// Datapath for the aligned byte stack engine: request latch, stack pointer,
// bound checks, word store and response register. Depends on abse_pkg and abse_ram.
module abse_dp
    import abse_pkg::*;
#(
    parameter int STACK_BYTES = 4096
) (
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  cmd_t    cmd,
    output status_t status,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output rsp_t    rsp
);

    localparam int PTR_W  = $clog2(STACK_BYTES + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int WORDS  = (STACK_BYTES + 3) / 4;
    localparam int ADDR_W = $clog2(WORDS);
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(STACK_BYTES);

    logic                 req_type_reg;
    logic [31:0]          value_reg;
    logic [WORDS_W-1:0]   words_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [1:0]           fault_reg;
    logic [31:0]          pop_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic [SUM_W-1:0]     bytes_ext;
    logic [SUM_W-1:0]     ptr_ext;
    logic [SUM_W-1:0]     push_sum;
    logic [SUM_W-1:0]     pop_diff;
    logic                 overflow;
    logic                 underflow;
    logic [ADDR_W-1:0]    base_addr;
    logic [ADDR_W-1:0]    ram_addr;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;

    // The pointer only moves in whole words, so the store is organized as
    // 32-bit words addressed by the pointer without its two low bits.
    assign bytes_ext = SUM_W'({words_reg, 2'b00});
    assign ptr_ext   = SUM_W'(ptr_reg);
    assign push_sum  = ptr_ext + bytes_ext;
    assign pop_diff  = ptr_ext - bytes_ext;
    assign overflow  = (req_type_reg == REQ_PUSH) && (push_sum > LIMIT);
    assign underflow = (req_type_reg == REQ_POP) && (bytes_ext > ptr_ext);

    assign base_addr = ptr_reg[ADDR_W+1:2];
    assign ram_addr  = cmd.write_word ? (base_addr + ADDR_W'(cnt_reg)) : base_addr;
    assign ram_wdata = (cnt_reg == '0) ? value_reg : 32'd0;

    assign status.zero_size = (words_reg == '0);
    assign status.fault_any = overflow || underflow;
    assign status.is_pop    = (req_type_reg == REQ_POP);
    assign status.last_word = ((WORDS_W'(cnt_reg) + WORDS_W'(1)) == words_reg);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    abse_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write_word),
        .re    (cmd.read_word),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req.req_type;
            value_reg    <= req.value;
            words_reg    <= WORDS_W'((6'(req.size_bytes) + 6'd3) >> 2);
        end
        if (cmd.check)
        begin
            cnt_reg <= '0;
            pop_reg <= 32'd0;
            if (words_reg == '0)
            begin
                fault_reg <= FAULT_NONE;
            end
            else if (overflow)
            begin
                fault_reg <= FAULT_OVER;
            end
            else if (underflow)
            begin
                fault_reg <= FAULT_UNDER;
            end
            else
            begin
                fault_reg <= FAULT_NONE;
            end
        end
        if (cmd.write_word)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.capture)
        begin
            pop_reg <= ram_rdata;
        end
        if (cmd.load_result)
        begin
            rsp_reg.pop_value   <= pop_reg;
            rsp_reg.fault       <= fault_reg;
            rsp_reg.stack_level <= LEVEL_W'(ptr_reg);
        end
    end

    // A pop moves the pointer before its read; a push moves it with its last word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.check && (req_type_reg == REQ_POP) && (words_reg != '0) && !underflow)
            begin
                ptr_reg <= PTR_W'(pop_diff);
            end
            else if (cmd.write_word && status.last_word)
            begin
                ptr_reg <= PTR_W'(push_sum);
            end
            if (cmd.load_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ design/aligned_byte_stack_engine_core.sv @@
// Aligned byte stack engine, top level.
// Request channel req_valid/req_ready/req carries req_type (push or pop), value
// and size_bytes; the size is rounded up to a multiple of four bytes.
// Response channel rsp_valid/rsp_ready/rsp returns one response per request:
// pop_value, fault (none, overflow, underflow) and the resulting stack_level.
// A push writes the value and then zero words, one 32-bit word per cycle, into a
// word-wide single-port RAM. A pop reads one word through the registered RAM read.
// A zero-size or faulted request goes from the check state straight to the finish
// state; a push writes its words in the write state and a pop passes through the
// read and read-wait states. The response is loaded in the finish state, and the
// next request is taken in the cycle after the response is loaded, from idle.
// The response sits in an output register; a request may be accepted while it
// waits. If the receiver stalls, a finished request holds in its final state
// until the output register frees, and no new request is taken meanwhile.
// Reset empties the stack (pointer zero). No clearing pass is needed: a pop only
// reads words below the pointer, which earlier pushes have always written.
// Depends on abse_pkg, abse_ctrl, abse_dp and abse_ram.
module aligned_byte_stack_engine_core
    import abse_pkg::*;
#(
    parameter int STACK_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t    cmd;
    status_t status;

    abse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    abse_dp #(
        .STACK_BYTES (STACK_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

@@ design/abse_checker.sv @@
// Port-level checker for the aligned byte stack engine, bound to the top level.
// Depends on abse_pkg.
module abse_checker
    import abse_pkg::*;
#(
    parameter int STACK_BYTES = 4096
) (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A held response must not change under backpressure.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

    // The engine works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in progress");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.fault == FAULT_NONE || rsp.fault == FAULT_OVER
                       || rsp.fault == FAULT_UNDER))
        else $error("undefined fault code");

    // A faulted request never returns data.
    a_fault_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.fault != FAULT_NONE) |-> (rsp.pop_value == 32'd0))
        else $error("faulted response carries data");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.stack_level) <= STACK_BYTES))
        else $error("stack level beyond stack size");

endmodule

bind aligned_byte_stack_engine_core abse_checker #(
    .STACK_BYTES (STACK_BYTES)
) u_abse_checker (.*);

@@ bench/tb_aligned_byte_stack_engine_core.sv @@
// Testbench for aligned_byte_stack_engine_core: push and pop requests against a byte-level
// mirror of the stack, with random idling on both channels.
// Depends on abse_pkg and the design files of the stack engine.
`timescale 1ns / 100ps

module tb_aligned_byte_stack_engine_core;
    import abse_pkg::*;

    localparam int STACK_BYTES  = 4096;
    localparam int RANDOM_ITEMS = 1880;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 12;

    // Byte-exact copy of the stack, plus the responses still owed by the block.
    class stack_mirror;
        logic [7:0]  bytes [STACK_BYTES];
        int unsigned level;
        rsp_t        due [$];
        int          mismatches;

        function new();
            foreach (bytes[i])
                bytes[i] = 8'h00;
            level = 0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        function void apply_request(req_t r);
            rsp_t        e;
            int unsigned sz;
            sz = (int'(r.size_bytes) + 3) / 4 * 4;
            e.pop_value = 32'h0;
            e.fault = FAULT_NONE;
            if (sz == 0)
            begin
                // Nothing moves; the level is reported as it stands.
            end
            else if (r.req_type == REQ_PUSH)
            begin
                if (level + sz > STACK_BYTES)
                    e.fault = FAULT_OVER;
                else
                begin
                    for (int i = 0; i < sz; i++)
                        bytes[level + i] = (i < 4) ? r.value[8*i +: 8] : 8'h00;
                    level += sz;
                end
            end
            else
            begin
                if (sz > level)
                    e.fault = FAULT_UNDER;
                else
                begin
                    level -= sz;
                    e.pop_value = {bytes[level + 3], bytes[level + 2],
                                   bytes[level + 1], bytes[level]};
                end
            end
            e.stack_level = level[LEVEL_W-1:0];
            due.insert(due.size(), e);
        endfunction

        function void match_response(rsp_t got);
            rsp_t e;
            if (due.size() == 0)
            begin
                $error("response with none outstanding: pop_value %h fault %0d level %0d",
                       got.pop_value, got.fault, got.stack_level);
                mismatches++;
                return;
            end
            e = due.pop_front();
            if (got.pop_value !== e.pop_value)
            begin
                $error("pop_value: expected %h, got %h", e.pop_value, got.pop_value);
                mismatches++;
            end
            if (got.fault !== e.fault)
            begin
                $error("fault: expected %0d, got %0d", e.fault, got.fault);
                mismatches++;
            end
            if (got.stack_level !== e.stack_level)
            begin
                $error("stack_level: expected %0d, got %0d", e.stack_level, got.stack_level);
                mismatches++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    stack_mirror mirror = new();
    bit          calm_req = 1'b0;
    bit          calm_rsp = 1'b0;
    int unsigned cycles = 0;

    aligned_byte_stack_engine_core #(.STACK_BYTES(STACK_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_aligned_byte_stack_engine_core: errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t make_request(logic kind, logic [31:0] val, logic [4:0] sz);
        req_t r;
        r.req_type = kind;
        r.value = val;
        r.size_bytes = sz;
        return r;
    endfunction

    function automatic req_t draw_request(int push_pct);
        req_t r;
        int   pick;
        r.req_type = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.size_bytes = 5'd0;
        else if (pick < 50)
            r.size_bytes = 5'($urandom_range(1, 16));
        else
            r.size_bytes = 5'($urandom_range(17, 31));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.value = 32'h0000_0000;
        else if (pick < 10)
            r.value = 32'hFFFF_FFFF;
        else
            r.value = $urandom();
        return r;
    endfunction

    task automatic send_request(input req_t r);
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        mirror.apply_request(r);
    endtask

    task automatic hold_sender();
        int gap;
        gap = idle_len(calm_req);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending until every owed response has come back.
    task automatic settle_stack();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.outstanding() != 0);
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_len(calm_rsp);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            mirror.match_response(rsp);
        end
    end

    initial
    begin
        req_t directed [$];
        int   sent;
        int   phase;
        int   span;
        int   push_pct;

        // Zero sizes, underflow on empty, value extremes, rounding of every size band,
        // and pops that land on the zero padding of a wide push.
        directed = '{
            make_request(REQ_PUSH, 32'h1234_5678, 5'd0),
            make_request(REQ_POP,  32'h0,         5'd0),
            make_request(REQ_POP,  32'h0,         5'd4),
            make_request(REQ_PUSH, 32'hFFFF_FFFF, 5'd1),
            make_request(REQ_PUSH, 32'h0000_0000, 5'd4),
            make_request(REQ_PUSH, 32'hA5A5_5A5A, 5'd5),
            make_request(REQ_PUSH, 32'h1234_5678, 5'd16),
            make_request(REQ_PUSH, 32'h8000_0001, 5'd17),
            make_request(REQ_PUSH, 32'h7FFF_FFFE, 5'd31),
            make_request(REQ_POP,  32'hFFFF_FFFF, 5'd31),
            make_request(REQ_POP,  32'h0,         5'd17),
            make_request(REQ_POP,  32'h0,         5'd16),
            make_request(REQ_POP,  32'h0,         5'd5),
            make_request(REQ_POP,  32'h0,         5'd8),
            make_request(REQ_POP,  32'h0,         5'd1),
            make_request(REQ_PUSH, 32'hCAFE_F00D, 5'd0),
            make_request(REQ_POP,  32'h0,         5'd3),
            make_request(REQ_PUSH, 32'hDEAD_BEEF, 5'd12),
            make_request(REQ_POP,  32'h0,         5'd4),
            make_request(REQ_POP,  32'h0,         5'd8),
            make_request(REQ_POP,  32'h0,         5'd4)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_request(directed[i]);
            hold_sender();
        end
        settle_stack();

        // Phases cycle through filling to overflow, mixed traffic and draining to underflow.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm_req = ($urandom_range(0, 4) == 0);
            calm_rsp = ($urandom_range(0, 4) == 0);
            case (phase % 3)
                0:
                begin
                    push_pct = 92;
                    span = $urandom_range(250, 380);
                end
                1:
                begin
                    push_pct = 50;
                    span = $urandom_range(150, 250);
                end
                default:
                begin
                    push_pct = 8;
                    span = $urandom_range(250, 380);
                end
            endcase
            for (int n = 0; n < span && sent < RANDOM_ITEMS; n++)
            begin
                send_request(draw_request(push_pct));
                sent++;
                if (n + 1 < span && sent < RANDOM_ITEMS)
                    hold_sender();
            end
            settle_stack();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("tb_aligned_byte_stack_engine_core: clean");
        else
            $display("tb_aligned_byte_stack_engine_core: errors");
        $finish;
    end

endmodule
